/* src/lpfr_pkg.sv */
// ----------------------------------------------------------------------------
// lpfr_pkg: shared types and constants of the length-prefixed frame receiver
// Header layout, event codes and the result record that the framing logic
// hands to the output register.
// ----------------------------------------------------------------------------
package lpfr_pkg;

   localparam int unsigned HEADER_BYTES    = 9;
   localparam int unsigned HDR_CNT_W       = 4;
   localparam int unsigned LEN_W           = 32;
   localparam int unsigned BODY_CNT_W      = LEN_W + 1;
   localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 32'd1048576;

   // byte positions inside the header
   localparam logic [HDR_CNT_W-1:0] HDR_POS_VERSION = 4'd0;
   localparam logic [HDR_CNT_W-1:0] HDR_POS_MSG_END = 4'd4;
   localparam logic [HDR_CNT_W-1:0] HDR_POS_FINAL   = 4'(HEADER_BYTES - 1);

   typedef enum logic [1:0] {
      EV_HDR_OK  = 2'd0,
      EV_HDR_BAD = 2'd1,
      EV_BODY    = 2'd2
   } event_type;

   typedef struct packed {
      event_type        event_res;
      logic [7:0]       body_byte;
      logic             in_value_part;
      logic             last;
      logic [7:0]       version;
      logic [LEN_W-1:0] message_length;
      logic [LEN_W-1:0] value_length;
   } result_type;

endpackage

/* src/lpfr_deframer.sv */
// ----------------------------------------------------------------------------
// lpfr_deframer: header collection and body tracking
// Holds the framing state and turns one registered byte into at most one
// result record in the same cycle.
// ----------------------------------------------------------------------------
module lpfr_deframer
   import lpfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       data_byte,
   input  logic [LEN_W-1:0] max_length,
   output logic             res_valid,
   output result_type       res
);

   logic                  in_body_ff, in_body_in;
   logic [HDR_CNT_W-1:0]  header_count_ff, header_count_in;
   logic [7:0]            version_ff, version_in;
   logic [LEN_W-1:0]      msg_len_ff, msg_len_in;
   logic [LEN_W-1:0]      val_len_ff, val_len_in;
   logic [BODY_CNT_W-1:0] body_count_ff, body_count_in;
   logic [BODY_CNT_W-1:0] body_total_ff, body_total_in;
   logic [BODY_CNT_W-1:0] body_next;
   logic                  too_long;
   logic                  empty_msg;
   logic                  body_last;

   always_comb begin
      in_body_in      = in_body_ff;
      header_count_in = header_count_ff;
      version_in      = version_ff;
      msg_len_in      = msg_len_ff;
      val_len_in      = val_len_ff;
      body_count_in   = body_count_ff;
      body_total_in   = body_total_ff;
      res_valid       = 1'b0;

      // shift the byte into its header field
      if (header_count_ff == HDR_POS_VERSION) begin
         version_in = data_byte;
      end else if (header_count_ff <= HDR_POS_MSG_END) begin
         msg_len_in = {msg_len_ff[LEN_W-9:0], data_byte};
      end else begin
         val_len_in = {val_len_ff[LEN_W-9:0], data_byte};
      end

      too_long  = (msg_len_in > max_length) || (val_len_in > max_length);
      empty_msg = (msg_len_in == '0) && (val_len_in == '0);
      body_next = body_count_ff + BODY_CNT_W'(1);
      body_last = (body_next >= body_total_ff);

      res.body_byte     = 8'd0;
      res.in_value_part = 1'b0;
      res.last          = 1'b0;
      res.event_res     = EV_HDR_OK;

      if (in_body_ff) begin
         version_in        = version_ff;
         msg_len_in        = msg_len_ff;
         val_len_in        = val_len_ff;
         res.event_res     = EV_BODY;
         res.body_byte     = data_byte;
         res.in_value_part = (body_count_ff >= {1'b0, msg_len_ff});
         res.last          = body_last;
         if (step) begin
            res_valid     = 1'b1;
            body_count_in = body_last ? '0 : body_next;
            in_body_in    = !body_last;
         end
      end else begin
         if (too_long) begin
            res.event_res = EV_HDR_BAD;
         end else begin
            res.last = empty_msg;
         end
         if (step) begin
            if (header_count_ff == HDR_POS_FINAL) begin
               res_valid       = 1'b1;
               header_count_in = '0;
               if (!too_long) begin
                  body_count_in = '0;
                  body_total_in = {1'b0, msg_len_in} + {1'b0, val_len_in};
                  in_body_in    = !empty_msg;
               end
            end else begin
               header_count_in = header_count_ff + HDR_CNT_W'(1);
            end
         end else begin
            version_in = version_ff;
            msg_len_in = msg_len_ff;
            val_len_in = val_len_ff;
         end
      end

      res.version        = version_in;
      res.message_length = msg_len_in;
      res.value_length   = val_len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff      <= 1'b0;
         header_count_ff <= '0;
      end else begin
         in_body_ff      <= in_body_in;
         header_count_ff <= header_count_in;
      end
   end

   always_ff @(posedge clock) begin
      version_ff    <= version_in;
      msg_len_ff    <= msg_len_in;
      val_len_ff    <= val_len_in;
      body_count_ff <= body_count_in;
      body_total_ff <= body_total_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      header_count_ff <= HDR_POS_FINAL)
      else $error("header count ran past the header");

   assert property (@(posedge clock) disable iff (reset)
      in_body_ff |-> header_count_ff == '0)
      else $error("header count not cleared while in body");

   assert property (@(posedge clock) disable iff (reset)
      in_body_ff |-> body_count_ff < body_total_ff)
      else $error("body count reached body length without closing frame");

   assert property (@(posedge clock) disable iff (reset)
      (step && res_valid && res.last) |=> !in_body_ff)
      else $error("frame closed but still in body");

endmodule

/* src/length_prefixed_frame_receiver.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver: byte-stream message deframer
// Collects the 9-byte header of each message, checks both lengths against
// max_length and tags the following body bytes as message or value section.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one stream byte per transfer (req_valid / req_stall).
//   rsp_*  : zero or one result per byte (rsp_valid / rsp_stall); the first
//            eight header bytes give no result, the ninth gives a header
//            accepted or header invalid event, every body byte gives a body
//            event. rsp_last marks the end of a complete message.
//   csr_*  : csr_wr_en writes csr_wr_data to max_length in the same edge;
//            write only while no byte is in flight.
// Timing: a byte transfer is taken into the input register; the framing
//   logic turns it into a result combinationally, and the result register
//   loads it when it advances and presents it on rsp_*. Throughput: one byte
//   per cycle while no result is held by rsp_stall; the framing logic between
//   the two registers handles a byte combinationally.
// Reset: synchronous; drops any partial header or body, empties both
//   registers and sets max_length to 1048576.
// Stall: a stalled result holds; the input register keeps taking a byte
//   until it is full behind the held result, then req_stall rises.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver
   import lpfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // configuration
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data,
   // byte stream in
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   // results out
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_event_res,
   output logic [7:0]       rsp_body_byte,
   output logic             rsp_in_value_part,
   output logic             rsp_last,
   output logic [7:0]       rsp_version,
   output logic [LEN_W-1:0] rsp_message_length,
   output logic [LEN_W-1:0] rsp_value_length
);

   logic             max_length_ff;
   logic [LEN_W-1:0] max_len_ff;
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             rsp_valid_ff;
   result_type       rsp_ff;
   logic             advance;
   logic             step;
   logic             res_valid;
   result_type       res;

   // advance the result register whenever it is empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LENGTH_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   // tracks that the config register has been written since reset (status only)
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= 1'b0;
      end else if (csr_wr_en) begin
         max_length_ff <= 1'b1;
      end
   end

   // input register: take a new transfer whenever not stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_data_byte;
      end
   end

   lpfr_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (in_byte_ff),
      .max_length (max_len_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   // result register: load on advance, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_ff.event_res;
   assign rsp_body_byte      = rsp_ff.body_byte;
   assign rsp_in_value_part  = rsp_ff.in_value_part;
   assign rsp_last           = rsp_ff.last;
   assign rsp_version        = rsp_ff.version;
   assign rsp_message_length = rsp_ff.message_length;
   assign rsp_value_length   = rsp_ff.value_length;

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a held result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_res != EV_BODY) |->
         (rsp_ff.body_byte == 8'd0 && !rsp_ff.in_value_part))
      else $error("header event carries body data");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_res == EV_HDR_BAD) |-> !rsp_ff.last)
      else $error("invalid header marked last");

   assert property (@(posedge clock) disable iff (reset)
      (max_length_ff && !csr_wr_en) |=> $stable(max_len_ff))
      else $error("max_length changed without a write");

endmodule
